[rtl/cdsd_pkg.sv]
// Shared types, constants and helpers for the card deck shuffle and deal block.
package cdsd_pkg;

    localparam int DECK_SIZE      = 52;
    localparam int LAST_POS       = DECK_SIZE - 1;
    localparam int RANKS_PER_SUIT = 13;
    localparam int CODE_W         = 6;
    localparam int RANK_W         = 4;
    localparam int SUIT_W         = 2;
    localparam int PASS_W         = 4;
    localparam int RND_W          = 31;
    localparam int DIV_CNT_W      = $clog2(RND_W);
    localparam int DEF_SHUFFLE_PASSES = 7;

    typedef enum logic [1:0] {
        KIND_INIT    = 2'd0,
        KIND_SHUFFLE = 2'd1,
        KIND_DEAL    = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RDX,
        ST_RDY,
        ST_WRX,
        ST_WRY,
        ST_DEAL_RD,
        ST_DEAL_LATCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic init;
        logic div_step;
        logic rd_x;
        logic rd_y;
        logic wr_x;
        logic wr_y;
        logic deal_rd;
        logic deal_latch;
        logic load_out;
    } cdsd_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } cdsd_status_t;

    // Splits a card code into its suit; codes above the deck range map to the top suit.
    function automatic logic [SUIT_W-1:0] code_suit(input logic [CODE_W-1:0] code);
        logic [SUIT_W-1:0] s;
        if (code >= CODE_W'(3 * RANKS_PER_SUIT))
            s = 2'd3;
        else if (code >= CODE_W'(2 * RANKS_PER_SUIT))
            s = 2'd2;
        else if (code >= CODE_W'(RANKS_PER_SUIT))
            s = 2'd1;
        else
            s = 2'd0;
        return s;
    endfunction

    function automatic logic [RANK_W-1:0] code_rank(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] base;
        base = CODE_W'(code_suit(code) * RANKS_PER_SUIT);
        return RANK_W'(code - base);
    endfunction

endpackage

[rtl/cdsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/cdsd_datapath.sv]
// Datapath: deck memory with valid bits, serial modulo unit, counters and output register.
module cdsd_datapath #(
    parameter int SHUFFLE_PASSES = cdsd_pkg::DEF_SHUFFLE_PASSES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdsd_pkg::cdsd_cmd_t           cmd,
    output cdsd_pkg::cdsd_status_t        status,
    input  logic [1:0]                    kind,
    input  logic [cdsd_pkg::RND_W-1:0]    random_value,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [cdsd_pkg::CODE_W-1:0]   card_code,
    output logic [cdsd_pkg::RANK_W-1:0]   card_rank,
    output logic [cdsd_pkg::SUIT_W-1:0]   card_suit,
    output logic                          shuffle_done
);

    import cdsd_pkg::*;

    logic [1:0]           kind_reg;
    logic [RND_W-1:0]     quo_reg;
    logic [CODE_W-1:0]    rem_reg, rem_next;
    logic [CODE_W-1:0]    div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CODE_W-1:0]    swap_reg, swap_next;
    logic [PASS_W-1:0]    pass_reg, pass_next;
    logic [CODE_W-1:0]    ptr_reg, ptr_next;
    logic                 done_reg, done_next;
    logic [CODE_W-1:0]    dx_reg;
    logic [CODE_W-1:0]    y_reg;
    logic [DECK_SIZE-1:0] valid_reg;
    logic [CODE_W-1:0]    rd_addr_reg;
    logic                 rd_valid_reg;
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic [SUIT_W-1:0]    suit_reg;
    logic                 sdone_reg;

    logic [CODE_W-1:0]    x_eff;
    logic [CODE_W-1:0]    ptr_inc;
    logic [CODE_W:0]      trial;
    logic                 trial_ge;
    logic                 ram_we, ram_re;
    logic [CODE_W-1:0]    ram_waddr, ram_wdata, ram_raddr, ram_q;
    logic [CODE_W-1:0]    rd_data;
    logic [CODE_W-1:0]    swap_inc;
    logic [PASS_W:0]      pass_inc;

    // Swap position is kept within range, but fold anything at or past the end back to zero.
    assign x_eff   = (swap_reg >= CODE_W'(LAST_POS)) ? '0 : swap_reg;
    assign ptr_inc = (ptr_reg == CODE_W'(LAST_POS)) ? '0 : ptr_reg + 1'b1;

    // One restoring-division step per cycle; only the remainder is kept.
    assign trial    = {rem_reg, quo_reg[RND_W-1]};
    assign trial_ge = trial >= {1'b0, div_reg};
    assign rem_next = trial_ge ? CODE_W'(trial - {1'b0, div_reg}) : trial[CODE_W-1:0];

    assign status.div_last = (cnt_reg == DIV_CNT_W'(RND_W - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    // An entry not yet written since init or reset reads as its own index.
    assign rd_data = rd_valid_reg ? ram_q : rd_addr_reg;

    always_comb
    begin
        ram_re    = cmd.rd_x || cmd.rd_y || cmd.deal_rd;
        ram_raddr = x_eff;
        if (cmd.rd_y)
            ram_raddr = CODE_W'(x_eff + rem_reg);
        else if (cmd.deal_rd)
            ram_raddr = ptr_inc;
        ram_we    = cmd.wr_x || cmd.wr_y;
        ram_waddr = cmd.wr_y ? y_reg : x_eff;
        ram_wdata = cmd.wr_y ? dx_reg : rd_data;
    end

    cdsd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DECK_SIZE)
    ) u_deck (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Counter update on init, on a deal read and at the end of a swap.
    always_comb
    begin
        swap_inc  = x_eff + 1'b1;
        pass_inc  = {1'b0, pass_reg} + 1'b1;
        swap_next = swap_reg;
        pass_next = pass_reg;
        ptr_next  = ptr_reg;
        done_next = 1'b0;
        if (cmd.init)
        begin
            swap_next = '0;
            pass_next = '0;
            ptr_next  = CODE_W'(LAST_POS);
        end
        else if (cmd.deal_rd)
        begin
            ptr_next = ptr_inc;
        end
        else if (cmd.wr_y)
        begin
            if (swap_inc >= CODE_W'(LAST_POS))
            begin
                swap_next = '0;
                if (pass_inc >= (PASS_W + 1)'(SHUFFLE_PASSES))
                begin
                    pass_next = '0;
                    ptr_next  = CODE_W'(LAST_POS);
                    done_next = 1'b1;
                end
                else
                begin
                    pass_next = pass_inc[PASS_W-1:0];
                end
            end
            else
            begin
                swap_next = swap_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg      <= '0;
            pass_reg      <= '0;
            ptr_reg       <= CODE_W'(LAST_POS);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            swap_reg <= swap_next;
            pass_reg <= pass_next;
            ptr_reg  <= ptr_next;
            if (cmd.init)
                valid_reg <= '0;
            else if (ram_we)
                valid_reg[ram_waddr] <= 1'b1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            quo_reg  <= random_value;
            rem_reg  <= '0;
            div_reg  <= CODE_W'(DECK_SIZE) - x_eff;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (ram_re)
        begin
            rd_addr_reg  <= ram_raddr;
            rd_valid_reg <= valid_reg[ram_raddr];
        end
        if (cmd.rd_y)
        begin
            dx_reg <= rd_data;
            y_reg  <= CODE_W'(x_eff + rem_reg);
        end
        else if (cmd.deal_latch)
        begin
            dx_reg <= rd_data;
        end
        if (cmd.wr_y)
            done_reg <= done_next;
        if (cmd.load_out)
        begin
            if (kind_reg == KIND_DEAL)
            begin
                code_reg <= dx_reg;
                rank_reg <= code_rank(dx_reg);
                suit_reg <= code_suit(dx_reg);
            end
            else
            begin
                code_reg <= '0;
                rank_reg <= '0;
                suit_reg <= '0;
            end
            sdone_reg <= (kind_reg == KIND_SHUFFLE) && done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign card_code    = code_reg;
    assign card_rank    = rank_reg;
    assign card_suit    = suit_reg;
    assign shuffle_done = sdone_reg;

endmodule

[rtl/cdsd_ctrl.sv]
// Controller: sequences init, shuffle swap and deal requests over the datapath.
module cdsd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  cdsd_pkg::cdsd_status_t status,
    output cdsd_pkg::cdsd_cmd_t    cmd
);

    import cdsd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (kind == KIND_INIT)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (kind == KIND_SHUFFLE)
                        state_next = ST_DIV;
                    else if (kind == KIND_DEAL)
                        state_next = ST_DEAL_RD;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_RDX;
            end
            ST_RDX:
            begin
                cmd.rd_x   = 1'b1;
                state_next = ST_RDY;
            end
            ST_RDY:
            begin
                cmd.rd_y   = 1'b1;
                state_next = ST_WRX;
            end
            ST_WRX:
            begin
                cmd.wr_x   = 1'b1;
                state_next = ST_WRY;
            end
            ST_WRY:
            begin
                cmd.wr_y   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_DEAL_RD:
            begin
                cmd.deal_rd = 1'b1;
                state_next  = ST_DEAL_LATCH;
            end
            ST_DEAL_LATCH:
            begin
                cmd.deal_latch = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/card_deck_shuffle_deal_core.sv]
// Top level of the card deck shuffle and deal block.
// A request on the input channel (in_valid/in_ready) carries kind and random_value.
// Kind 0 refills the deck in order and clears the shuffle counters, kind 1 performs
// one Fisher-Yates swap, kind 2 deals the next card, and any other kind returns zeros.
// Every request yields exactly one result on the output channel (out_valid/out_ready):
// card_code, card_rank and card_suit for a deal, shuffle_done on the last swap of a shuffle.
// Requests are handled one at a time. After acceptance an init or unused kind goes
// straight to its finish step, a deal reads and latches the next card, and a shuffle
// swap runs the bit-serial remainder unit and then the two reads and two writes of the swap
// through the single write port and single read port of the deck memory.
// A new request can be accepted in the cycle after the previous result is loaded.
// The output register holds a result until it is taken; while the receiver stalls,
// the next request is still accepted and worked on, and waits in its last step.
// Reset, or an init request, marks every deck entry unwritten so that it reads as
// its own index, giving an ordered deck at once; no clearing pass is needed.
// After reset the deal pointer is 51, so the first deal reads deck position 0 (card 0 if no swap has run).
module card_deck_shuffle_deal_core #(
    parameter int SHUFFLE_PASSES = cdsd_pkg::DEF_SHUFFLE_PASSES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [cdsd_pkg::RND_W-1:0]  random_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cdsd_pkg::CODE_W-1:0] card_code,
    output logic [cdsd_pkg::RANK_W-1:0] card_rank,
    output logic [cdsd_pkg::SUIT_W-1:0] card_suit,
    output logic                        shuffle_done
);

    import cdsd_pkg::*;

    cdsd_cmd_t    cmd;
    cdsd_status_t status;

    cdsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    cdsd_datapath #(
        .SHUFFLE_PASSES (SHUFFLE_PASSES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .random_value (random_value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .card_code    (card_code),
        .card_rank    (card_rank),
        .card_suit    (card_suit),
        .shuffle_done (shuffle_done)
    );

endmodule
